### design/lmpg_pkg.sv
`timescale 1ns / 1ps

package lmpg_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE_CHAR = 2'd0,
        FUNC_RESTART    = 2'd1,
        FUNC_TICK       = 2'd2,
        FUNC_QUERY      = 2'd3
    } func_t;

    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_SCROLL_SPEED  = 3'd2;
    localparam logic [2:0] CFG_TEXT_LENGTH   = 3'd3;
    localparam logic [2:0] CFG_INVERT        = 3'd4;

    localparam logic [16:0] TW_MAX      = 17'd131071;
    localparam logic [13:0] RECIP7      = 14'd9363;     // ceil(2^16 / 7)
    localparam logic [22:0] RECIP25     = 23'd5368710;  // ceil(2^27 / 25)
    localparam logic [18:0] RECIP6      = 19'd349526;   // ceil(2^21 / 6)
    localparam logic [4:0]  RECIP_BITS  = 5'd18;

    // 5x7 glyph, row 0 in the top five bits, bit 4 of a row = leftmost column
    function automatic logic [34:0] font_glyph(input logic [7:0] code);
        logic [7:0]  up;
        logic [34:0] g;
        up = (code >= "a" && code <= "z") ? code - 8'd32 : code;
        unique case (up)
            "A":  g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            "B":  g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
            "C":  g = {5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd15};
            "D":  g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
            "E":  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
            "F":  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
            "G":  g = {5'd15, 5'd16, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
            "H":  g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            "I":  g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
            "J":  g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12};
            "K":  g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
            "L":  g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            "M":  g = {5'd17, 5'd27, 5'd21, 5'd17, 5'd17, 5'd17, 5'd17};
            "N":  g = {5'd17, 5'd25, 5'd21, 5'd21, 5'd19, 5'd17, 5'd17};
            "O":  g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            "P":  g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
            "Q":  g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
            "R":  g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
            "S":  g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
            "T":  g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
            "U":  g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            "V":  g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            "W":  g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd27, 5'd17};
            "X":  g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
            "Y":  g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
            "Z":  g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
            "0":  g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
            "1":  g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
            "2":  g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
            "3":  g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
            "4":  g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
            "5":  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
            "6":  g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
            "7":  g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
            "8":  g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
            "9":  g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
            ".":  g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
            ",":  g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4,  5'd8};
            "!":  g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};
            "?":  g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4};
            ":":  g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
            ";":  g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd8,  5'd0};
            "'":  g = {5'd12, 5'd12, 5'd8,  5'd0,  5'd0,  5'd0,  5'd0};
            "-":  g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
            "+":  g = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
            "/":  g = {5'd1,  5'd2,  5'd4,  5'd4,  5'd8,  5'd16, 5'd0};
            "(":  g = {5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2};
            ")":  g = {5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8};
            default: g = 35'd0;
        endcase
        return g;
    endfunction

endpackage

### design/led_marquee_pixel_generator.sv
`timescale 1ns / 1ps

// Scrolling 5x7 dot-matrix marquee pixel generator.
// Input channel s_*: one word per valid/ready handshake. s_func selects a char
// write (s_char_slot, s_char_code), a layout restart, a scroll tick or a pixel
// query (s_pixel_x, s_pixel_y). Only a pixel query returns a word on m_*:
// m_pixel_lit and m_pixel_black (lit XOR invert).
// Configuration: cfg_wr_en, cfg_addr, cfg_wdata write screen width, height,
// scroll speed, text length and invert; write them only while the block is idle.
// Steps: a char write or a tick is done in the idle state as it is accepted.
// A pixel query runs through its chain of reciprocal multiplies (origin,
// column/row by scale, column by six) and the text memory read to a result.
// A restart sets scale, geometry and text width, then the bit-serial reciprocal
// of the glyph scale. One word is in work at a time; s_ready is high while idle.
// The result sits in an output register: a new word is accepted while it waits,
// and a finishing query holds in its last step while m_valid is high and
// m_ready is low. Reset clears the control, the layout (scroll 0, scale 1,
// cell width 6) and loads the default configuration; the text memory is not
// cleared and slots must be written before they are shown.
module led_marquee_pixel_generator
    import lmpg_pkg::*;
#(
    parameter int TEXT_CHARS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [6:0]  s_char_slot,
    input  logic [7:0]  s_char_code,
    input  logic [9:0]  s_pixel_x,
    input  logic [9:0]  s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pixel_lit,
    output logic        m_pixel_black,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);

    localparam int AW = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;
    localparam logic [8:0] LEN_MAX = 9'(TEXT_CHARS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RS_SCALE,
        ST_RS_GEOM,
        ST_RS_TEXT,
        ST_RS_SUB,
        ST_RS_RECIP,
        ST_Q_ORIG,
        ST_Q_DIFF,
        ST_Q_MUL,
        ST_Q_FIX,
        ST_Q_IDX,
        ST_Q_READ,
        ST_Q_LOOK
    } state_t;

    state_t state_reg;

    logic [10:0] screen_width_reg;
    logic [10:0] screen_height_reg;
    logic [8:0]  scroll_speed_reg;
    logic [7:0]  text_length_reg;
    logic        invert_reg;

    logic [23:0] scroll_pos_reg;
    logic [7:0]  scale_reg;
    logic [9:0]  top_row_reg;
    logic [9:0]  cell_width_reg;
    logic [16:0] text_width_reg;
    logic [21:0] tw_sub_reg;
    logic [18:0] recip_reg;
    logic [7:0]  div_rem_reg;
    logic [4:0]  div_cnt_reg;

    logic [9:0]  px_reg;
    logic [9:0]  py_reg;
    logic [19:0] origin_reg;
    logic        dark_reg;
    logic [17:0] dcol_reg;
    logic [9:0]  drow_reg;
    logic [17:0] qcol_reg;
    logic [9:0]  qrow_reg;
    logic [15:0] idx_reg;
    logic [2:0]  gcol_reg;
    logic [2:0]  grow_reg;
    logic [7:0]  rdata_reg;

    logic        m_valid_reg;
    logic        m_pixel_lit_reg;
    logic        m_pixel_black_reg;

    logic [7:0]  text_mem [TEXT_CHARS];

    logic [10:0] eff_w;
    logic [10:0] eff_h;
    logic [8:0]  eff_len;
    logic [14:0] width_sub;
    logic        s_fire;
    logic [8:0]  slot_w;
    logic        slot_ok;

    logic [10:0] avail;
    logic [24:0] scale_prod;
    logic [10:0] sc7;
    logic [10:0] top_diff;
    logic [9:0]  cw_calc;
    logic [18:0] tw_full;
    logic [16:0] tw_calc;
    logic [21:0] tw_sub;
    logic [8:0]  div_trial;
    logic        div_ge;
    logic [7:0]  div_rem_new;

    logic [23:0] scroll_dec;
    logic        scroll_wrap;

    logic [22:0] scroll_mag;
    logic [45:0] orig_prod;
    logic [19:0] orig_pos;
    logic [19:0] origin_calc;
    logic [20:0] diff;
    logic [11:0] rdiff;
    logic [36:0] pcol;
    logic [28:0] prow;
    logic [25:0] rcol;
    logic [17:0] rrow;
    logic [36:0] pidx;
    logic [17:0] gcol_full;
    logic [34:0] glyph;
    logic [5:0]  bit_pos;
    logic        glyph_bit;
    logic        out_free;

    always_comb begin
        eff_w = (screen_width_reg == 11'd0) ? 11'd1 :
                (screen_width_reg > 11'd1024) ? 11'd1024 : screen_width_reg;
        eff_h = (screen_height_reg < 11'd7) ? 11'd7 :
                (screen_height_reg > 11'd1024) ? 11'd1024 : screen_height_reg;
        eff_len = (9'(text_length_reg) > LEN_MAX) ? LEN_MAX : 9'(text_length_reg);
        width_sub = 15'(eff_w) * 15'd25;

        s_fire = s_valid && s_ready;
        slot_w = 9'(s_char_slot);
        slot_ok = slot_w < LEN_MAX || TEXT_CHARS > 255;

        avail = (eff_h >= 11'd27) ? eff_h - 11'd20 : 11'd7;
        scale_prod = 25'(avail) * 25'(RECIP7);
        sc7 = 11'(scale_reg) * 11'd7;
        top_diff = (eff_h - sc7) >> 1;
        cw_calc = 10'(scale_reg) * 10'd6;
        tw_full = 19'(eff_len) * 19'(cell_width_reg);
        tw_calc = (tw_full > 19'(TW_MAX)) ? TW_MAX : tw_full[16:0];
        tw_sub = 22'(text_width_reg) * 22'd25;
        div_trial = {div_rem_reg, div_cnt_reg == RECIP_BITS};
        div_ge = div_trial >= 9'(scale_reg);
        div_rem_new = div_ge ? 8'(div_trial - 9'(scale_reg)) : div_trial[7:0];

        scroll_dec = scroll_pos_reg - 24'(scroll_speed_reg);
        scroll_wrap = $signed(scroll_dec) < -$signed({2'b00, tw_sub_reg});

        scroll_mag = scroll_pos_reg[23] ? 23'(-scroll_pos_reg) : scroll_pos_reg[22:0];
        orig_prod = 46'(scroll_mag) * 46'(RECIP25);
        orig_pos = {1'b0, orig_prod[45:27]};
        origin_calc = scroll_pos_reg[23] ? -orig_pos : orig_pos;
        diff = 21'(px_reg) - {origin_reg[19], origin_reg};
        rdiff = 12'(py_reg) - 12'(top_row_reg);

        pcol = 37'(dcol_reg) * 37'(recip_reg);
        prow = 29'(drow_reg) * 29'(recip_reg);
        rcol = 26'(dcol_reg) - 26'(qcol_reg) * 26'(scale_reg);
        rrow = 18'(drow_reg) - 18'(qrow_reg) * 18'(scale_reg);
        pidx = 37'(qcol_reg) * 37'(RECIP6);
        gcol_full = qcol_reg - 18'(idx_reg) * 18'd6;

        glyph = font_glyph(rdata_reg);
        bit_pos = 6'(grow_reg) * 6'd5 + 6'(gcol_reg);
        glyph_bit = glyph[6'd34 - bit_pos];
        out_free = !m_valid_reg || m_ready;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_pixel_lit = m_pixel_lit_reg;
    assign m_pixel_black = m_pixel_black_reg;

    always_ff @(posedge aclk) begin
        if (s_fire && func_t'(s_func) == FUNC_WRITE_CHAR && slot_ok) begin
            text_mem[slot_w[AW-1:0]] <= s_char_code;
        end
        if (state_reg == ST_Q_READ) begin
            rdata_reg <= text_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            screen_width_reg <= 11'd400;
            screen_height_reg <= 11'd300;
            scroll_speed_reg <= 9'd130;
            text_length_reg <= 8'd0;
            invert_reg <= 1'b0;
            scroll_pos_reg <= 24'd0;
            scale_reg <= 8'd1;
            top_row_reg <= 10'd0;
            cell_width_reg <= 10'd6;
            text_width_reg <= 17'd0;
            tw_sub_reg <= 22'd0;
            recip_reg <= 19'(1 << 18);
            div_rem_reg <= 8'd0;
            div_cnt_reg <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SCREEN_WIDTH:  screen_width_reg <= cfg_wdata;
                    CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                    CFG_SCROLL_SPEED:  scroll_speed_reg <= cfg_wdata[8:0];
                    CFG_TEXT_LENGTH:   text_length_reg <= cfg_wdata[7:0];
                    CFG_INVERT:        invert_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != ST_Q_LOOK) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (func_t'(s_func))
                            FUNC_WRITE_CHAR: ;
                            FUNC_RESTART: state_reg <= ST_RS_SCALE;
                            FUNC_TICK: begin
                                if (eff_len != 9'd0) begin
                                    scroll_pos_reg <= scroll_wrap ? 24'(width_sub)
                                                                  : scroll_dec;
                                end
                            end
                            FUNC_QUERY: begin
                                px_reg <= s_pixel_x;
                                py_reg <= s_pixel_y;
                                state_reg <= ST_Q_ORIG;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RS_SCALE: begin
                    scale_reg <= scale_prod[23:16];
                    state_reg <= ST_RS_GEOM;
                end
                ST_RS_GEOM: begin
                    top_row_reg <= top_diff[9:0];
                    cell_width_reg <= cw_calc;
                    state_reg <= ST_RS_TEXT;
                end
                ST_RS_TEXT: begin
                    text_width_reg <= tw_calc;
                    state_reg <= ST_RS_SUB;
                end
                ST_RS_SUB: begin
                    tw_sub_reg <= tw_sub;
                    scroll_pos_reg <= 24'(width_sub);
                    div_rem_reg <= 8'd0;
                    div_cnt_reg <= RECIP_BITS;
                    state_reg <= ST_RS_RECIP;
                end
                ST_RS_RECIP: begin
                    div_rem_reg <= div_rem_new;
                    recip_reg <= {recip_reg[17:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                    if (div_cnt_reg == 5'd0) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_Q_ORIG: begin
                    origin_reg <= origin_calc;
                    dark_reg <= (11'(px_reg) >= eff_w) || (11'(py_reg) >= eff_h);
                    state_reg <= ST_Q_DIFF;
                end
                ST_Q_DIFF: begin
                    dcol_reg <= diff[17:0];
                    drow_reg <= rdiff[9:0];
                    if (diff[20] || diff[19:18] != 2'd0 || rdiff[11] || rdiff[10:0] >= sc7) begin
                        dark_reg <= 1'b1;
                    end
                    state_reg <= ST_Q_MUL;
                end
                ST_Q_MUL: begin
                    qcol_reg <= pcol[35:18];
                    qrow_reg <= prow[27:18];
                    state_reg <= ST_Q_FIX;
                end
                ST_Q_FIX: begin
                    if (rcol >= 26'(scale_reg)) begin
                        qcol_reg <= qcol_reg + 18'd1;
                    end
                    if (rrow >= 18'(scale_reg)) begin
                        qrow_reg <= qrow_reg + 10'd1;
                    end
                    state_reg <= ST_Q_IDX;
                end
                ST_Q_IDX: begin
                    idx_reg <= pidx[36:21];
                    state_reg <= ST_Q_READ;
                end
                ST_Q_READ: begin
                    gcol_reg <= gcol_full[2:0];
                    grow_reg <= qrow_reg[2:0];
                    if (idx_reg >= 16'(eff_len) || gcol_full[2:0] >= 3'd5) begin
                        dark_reg <= 1'b1;
                    end
                    state_reg <= ST_Q_LOOK;
                end
                ST_Q_LOOK: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_pixel_lit_reg <= !dark_reg && glyph_bit;
                        m_pixel_black_reg <= (!dark_reg && glyph_bit) ^ invert_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
